/* sv/llf_pkg.sv */
// ----------------------------------------------------------------------------
// llf_pkg
// Shared types and constants of the least-laxity-first tick scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llf_pkg;

    // Table size and time width
    localparam int MAX_TASKS = 8;
    localparam int TIME_BITS = 16;

    localparam int IDX_W    = $clog2(MAX_TASKS);
    localparam int CNT_W    = $clog2(MAX_TASKS + 1);
    localparam int LAX_W    = TIME_BITS + 2;
    localparam int ACTIVE_W = 4;
    localparam int SEL_W    = 3;

    // Packed stream widths
    localparam int IN_DATA_W  = 56;  // 3 + 16 + 16 + 16 = 51, padded
    localparam int OUT_DATA_W = 40;  // 16 + 3 + 18 = 37, padded

    // Function codes carried on s_tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // One task table entry
    typedef struct packed {
        logic [TIME_BITS-1:0] release_t;
        logic [TIME_BITS-1:0] deadline;
        logic [TIME_BITS-1:0] remaining;
    } task_entry_t;

    // Write port of the task table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        task_entry_t      data;
    } mem_wr_t;

    // Read port of the task table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* sv/llf_task_mem.sv */
// ----------------------------------------------------------------------------
// llf_task_mem
// Task table: one synchronous memory, one write and one registered read port.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llf_task_mem
    import llf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mem_wr_t     wr,
    input  wire mem_rd_t     rd,
    output task_entry_t      rd_data
);

    task_entry_t              mem [MAX_TASKS];
    task_entry_t              rd_raw_reg;
    logic [MAX_TASKS-1:0]     ent_valid_reg;
    logic                     rd_valid_reg;

    // Storage array
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_raw_reg <= mem[rd.addr];
        end
    end

    // Written-since-reset flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                ent_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= ent_valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

/* sv/least_laxity_first_scheduler.sv */
// ----------------------------------------------------------------------------
// least_laxity_first_scheduler
// Tick scheduler that picks the eligible task with the smallest laxity.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: s_tuser = 0 loads one task entry (remaining time, deadline,
//   release), s_tuser = 1 runs one scheduling tick. A load gives no result.
//   A tick scans table entries 0 .. N-1, N being the active task count
//   clamped to the table size, reading one entry a cycle from the task
//   memory through its single read port.
//   m_ channel: one transfer per tick with the tick time, the chosen task
//   and its laxity, or an idle flag. Results sit in an output register, so
//   loads and the scan of the next tick proceed while the receiver stalls;
//   a finished tick waits in its last state until the register frees up.
//   cfg_wr_en / cfg_wr_data set the active task count (reset value 8);
//   write it only while the block is idle.
//   Reset (aresetn low, synchronous) clears the time counter, the task
//   table (through valid bits) and any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module least_laxity_first_scheduler
    import llf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config
    input  wire logic                  cfg_wr_en,
    input  wire logic [ACTIVE_W-1:0]   cfg_wr_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // task_index, exec_time,
                                                  // deadline_time, release_time
    input  wire logic                  s_tuser,   // func
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // tick_number, selected_task,
                                                  // least_laxity
    output logic                       m_tuser    // task_chosen
);

    // Input field unpacking
    logic [SEL_W-1:0]     in_index;
    logic [TIME_BITS-1:0] in_exec;
    logic [TIME_BITS-1:0] in_deadline;
    logic [TIME_BITS-1:0] in_release;

    assign in_index    = s_tdata[2:0];
    assign in_exec     = s_tdata[18:3];
    assign in_deadline = s_tdata[34:19];
    assign in_release  = s_tdata[50:35];

    // Registers
    state_t                state_reg, state_next;
    logic [ACTIVE_W-1:0]   active_reg;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  best_found_reg, best_found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic signed [LAX_W-1:0] best_lax_reg, best_lax_next;
    task_entry_t           best_ent_reg, best_ent_next;

    logic                  out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0]  out_tick_reg;
    logic                  out_chosen_reg;
    logic [SEL_W-1:0]      out_sel_reg;
    logic [LAX_W-1:0]      out_lax_reg;

    // Memory ports
    mem_wr_t               mem_wr;
    mem_rd_t               mem_rd;
    task_entry_t           mem_q;

    llf_task_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_q)
    );

    // Handshake terms
    logic in_xfer;
    logic out_free;
    logic out_load;
    logic [CNT_W-1:0] active_cnt;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Active count clamped to the table size
    assign active_cnt = (int'(active_reg) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                       : CNT_W'(active_reg);

    // Laxity of the entry that is being compared
    logic signed [LAX_W-1:0] cur_lax;
    logic                    cur_elig;

    assign cur_lax  = $signed({2'b00, mem_q.deadline}) - $signed({2'b00, time_reg})
                    - $signed({2'b00, mem_q.remaining});
    assign cur_elig = rd_vld_reg && (mem_q.remaining != '0) && (mem_q.release_t <= time_reg);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        time_next       = time_reg;
        cnt_next        = cnt_reg;
        iss_next        = iss_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_lax_next   = best_lax_reg;
        best_ent_next   = best_ent_reg;
        out_load        = 1'b0;
        mem_wr          = '0;
        mem_rd          = '0;

        // compare stage, in the cycle after the read
        if (cur_elig && (!best_found_reg || (cur_lax < best_lax_reg))) begin
            best_found_next = 1'b1;
            best_idx_next   = rd_idx_reg;
            best_lax_next   = cur_lax;
            best_ent_next   = mem_q;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == FUNC_LOAD) begin
                        if (int'(in_index) < MAX_TASKS) begin
                            mem_wr.en             = 1'b1;
                            mem_wr.addr           = IDX_W'(in_index);
                            mem_wr.data.remaining = in_exec;
                            mem_wr.data.deadline  = in_deadline;
                            mem_wr.data.release_t = in_release;
                        end
                    end else begin
                        cnt_next        = active_cnt;
                        iss_next        = '0;
                        best_found_next = 1'b0;
                        best_idx_next   = '0;
                        best_lax_next   = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (iss_reg < cnt_reg) begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = iss_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[IDX_W-1:0];
                    iss_next    = iss_reg + 1'b1;
                end else begin
                    // last compare lands at this edge
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (best_found_reg) begin
                        mem_wr.en             = 1'b1;
                        mem_wr.addr           = best_idx_reg;
                        mem_wr.data           = best_ent_reg;
                        mem_wr.data.remaining = best_ent_reg.remaining - 1'b1;
                    end
                    time_next  = time_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= ACTIVE_W'(MAX_TASKS);
            time_reg      <= '0;
            cnt_reg       <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            cnt_reg       <= cnt_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
        end
    end

    // Scan payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_lax_reg   <= best_lax_next;
        best_ent_reg   <= best_ent_next;
    end

    // Output register
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_tick_reg   <= time_reg;
            out_chosen_reg <= best_found_reg;
            out_sel_reg    <= best_found_reg ? SEL_W'(best_idx_reg) : '0;
            out_lax_reg    <= best_found_reg ? best_lax_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_chosen_reg;
    assign m_tdata  = {{(OUT_DATA_W - TIME_BITS - SEL_W - LAX_W){1'b0}},
                       out_lax_reg, out_sel_reg, out_tick_reg};

    // Assertions
    a_iss_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_reg <= cnt_reg)
        else $error("scan issue counter ran past the active count");

    a_time_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (time_reg == $past(time_reg) + 1'b1))
        else $error("time counter did not advance by one on a tick");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !best_found_reg) |=> (out_sel_reg == '0 && out_lax_reg == '0))
        else $error("idle tick result carries a nonzero task or laxity");

    a_wb_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr.en && state_reg != ST_IDLE) |-> (state_reg == ST_DONE && best_found_reg))
        else $error("task table written outside a load or a tick write-back");

    a_no_read_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd.en |-> !mem_wr.en)
        else $error("task table read and written in the same cycle");

endmodule

`default_nettype wire

/* tb/llf_result_checker.sv */
// ----------------------------------------------------------------------------
// llf_result_checker
// Watches both streams of the least-laxity-first scheduler. It keeps its own
// copy of the task table, time counter and active task count, works out
// the schedule decision for every accepted tick and compares each result
// transfer with the oldest decision still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llf_result_checker
    import llf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [ACTIVE_W-1:0]   cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    pending
);

    // One schedule decision
    typedef struct {
        logic [TIME_BITS-1:0] tick_number;
        logic                 task_chosen;
        logic [SEL_W-1:0]     selected_task;
        logic [LAX_W-1:0]     least_laxity;
    } tick_decision_t;

    // Model state
    logic [TIME_BITS-1:0] remaining_time [MAX_TASKS];
    logic [TIME_BITS-1:0] deadline_tick  [MAX_TASKS];
    logic [TIME_BITS-1:0] release_tick   [MAX_TASKS];
    logic [TIME_BITS-1:0] now_tick;
    logic [ACTIVE_W-1:0]  active_count;

    tick_decision_t decisions_owed [$];

    // Scan the table, pick the least laxity task, charge it one tick, advance the time
    function automatic tick_decision_t pick_least_laxity();
        tick_decision_t d;
        int             scan_len;
        int             lax;
        int             best_lax;
        int             best_idx;
        bit             found;
        scan_len = (active_count > MAX_TASKS) ? MAX_TASKS : int'(active_count);
        found    = 1'b0;
        best_lax = 0;
        best_idx = 0;
        for (int i = 0; i < scan_len; i++) begin
            if (remaining_time[i] != '0 && release_tick[i] <= now_tick) begin
                lax = int'(deadline_tick[i]) - int'(now_tick) - int'(remaining_time[i]);
                // strict compare keeps the lowest index on ties
                if (!found || lax < best_lax) begin
                    found    = 1'b1;
                    best_idx = i;
                    best_lax = lax;
                end
            end
        end
        d.tick_number = now_tick;
        if (found) begin
            d.task_chosen   = 1'b1;
            d.selected_task = best_idx[SEL_W-1:0];
            d.least_laxity  = best_lax[LAX_W-1:0];
            remaining_time[best_idx] = remaining_time[best_idx] - 1'b1;
        end else begin
            d.task_chosen   = 1'b0;
            d.selected_task = '0;
            d.least_laxity  = '0;
        end
        now_tick = now_tick + 1'b1;
        return d;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
        end
    endfunction

    // Everything is sampled at the rising edge, before the block's own updates
    always @(posedge aclk) begin
        tick_decision_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                remaining_time[i] = '0;
                deadline_tick[i]  = '0;
                release_tick[i]   = '0;
            end
            now_tick     = '0;
            active_count = ACTIVE_W'(8);
            decisions_owed.delete();
        end else begin
            // result side first: a result never leaves in the cycle its tick arrives
            if (m_tvalid && m_tready) begin
                if (decisions_owed.size() == 0) begin
                    fail_count++;
                    $error("result transfer with no tick outstanding");
                end else begin
                    want = decisions_owed.pop_front();
                    compare_field("tick_number", 32'(want.tick_number), 32'(m_tdata[15:0]));
                    compare_field("task_chosen", 32'(want.task_chosen), 32'(m_tuser));
                    compare_field("selected_task", 32'(want.selected_task),
                                  32'(m_tdata[18:16]));
                    compare_field("least_laxity", 32'(want.least_laxity),
                                  32'(m_tdata[36:19]));
                end
            end
            if (cfg_wr_en)
                active_count = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_LOAD) begin
                    remaining_time[s_tdata[2:0]] = s_tdata[18:3];
                    deadline_tick[s_tdata[2:0]]  = s_tdata[34:19];
                    release_tick[s_tdata[2:0]]   = s_tdata[50:35];
                end else begin
                    decisions_owed.push_back(pick_least_laxity());
                end
            end
        end
        pending = decisions_owed.size();
    end

endmodule

/* tb/tb_least_laxity_first_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_least_laxity_first_scheduler
// Drives loads and ticks into the scheduler through a directed opening and
// several random phases at different active task counts, including a
// short run of idle ticks with no active entries.
// Both streams stall at random outside the no-gap stretches; llf_result_checker does the comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_least_laxity_first_scheduler;
    import llf_pkg::*;

    // Cycles to let a scan finish after the last expected result
    localparam int SETTLE_CYCLES = 24;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [ACTIVE_W-1:0]   cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // task_index, exec_time, deadline_time, release_time
    logic                  s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;   // tick_number, selected_task, least_laxity
    logic                  m_tuser;   // task_chosen

    int                    fail_count;
    int                    pending;
    bit                    gaps_on;
    logic [TIME_BITS-1:0]  tick_clock;  // ticks handed to the block so far

    least_laxity_first_scheduler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    llf_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver stalls at random, about 20 percent of the time, while gaps are enabled
    always @(posedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(0, 99) >= 20) : 1'b1;
    end

    // Hard stop
    initial begin
        #40_000_000;
        $display("** least_laxity_first_scheduler: FAILED **");
        $finish;
    end

    // One input transfer; valid stays high when the next call follows at once
    task automatic send_item(input logic func, input logic [2:0] idx,
                             input logic [15:0] exec_t, input logic [15:0] dead_t,
                             input logic [15:0] rel_t);
        while (gaps_on && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= IN_DATA_W'({rel_t, dead_t, exec_t, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (func == FUNC_TICK)
            tick_clock = tick_clock + 1'b1;
    endtask

    task automatic load_task(input logic [2:0] idx, input logic [15:0] exec_t,
                             input logic [15:0] dead_t, input logic [15:0] rel_t);
        send_item(FUNC_LOAD, idx, exec_t, dead_t, rel_t);
    endtask

    // Tick payload is don't-care; random bits keep tdata busy
    task automatic send_tick();
        send_item(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Wait until every owed result is out and the block has gone quiet
    task automatic finish_work();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] count);
        finish_work();
        cfg_wr_data <= count;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly plausible task sets around the current time, some raw noise
    task automatic random_run(input int n_items);
        logic [15:0] exec_t, dead_t, rel_t;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 9) < 2) begin
                    exec_t = 16'($urandom);
                    dead_t = 16'($urandom);
                    rel_t  = 16'($urandom);
                end else begin
                    exec_t = 16'($urandom_range(0, 12));
                    dead_t = 16'(tick_clock + $urandom_range(0, 50) - 16'd10);
                    rel_t  = 16'(tick_clock + $urandom_range(0, 10) - 16'd4);
                end
                load_task(3'($urandom_range(0, 7)), exec_t, dead_t, rel_t);
            end else begin
                send_tick();
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tuser     = FUNC_LOAD;
        s_tdata     = '0;
        gaps_on     = 1'b1;
        tick_clock  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table gives an idle tick
        send_tick();
        // largest remaining time with deadline zero: deeply negative laxity
        load_task(3'd0, 16'hFFFF, 16'h0000, 16'h0000);
        send_tick();
        // top deadline, near-top positive laxity
        load_task(3'd7, 16'h0001, 16'hFFFF, 16'h0000);
        load_task(3'd0, 16'h0000, 16'h0000, 16'h0000);
        send_tick();
        // tie between two entries goes to the lower index
        load_task(3'd1, 16'd5, 16'd100, 16'd0);
        load_task(3'd2, 16'd5, 16'd100, 16'd0);
        send_tick();
        send_tick();
        send_tick();
        // entry 3 not released (release time FFFF), entry 4 released at tick 8
        load_task(3'd3, 16'd3, 16'd20, 16'hFFFF);
        load_task(3'd4, 16'd2, 16'd10, 16'd8);
        repeat (6) send_tick();

        random_run(400);

        // Single active entry
        write_active(4'd1);
        random_run(200);

        // Count above the table size is clamped; no stalls in this stretch
        write_active(4'd15);
        gaps_on = 1'b0;
        random_run(300);
        gaps_on = 1'b1;

        write_active(ACTIVE_W'($urandom_range(2, 7)));
        random_run(300);

        // No active entries: every tick idle
        write_active(4'd0);
        gaps_on = 1'b0;
        repeat (12) send_tick();

        // Clean table, then a few directed entries
        write_active(4'd8);
        for (int i = 0; i < MAX_TASKS; i++)
            load_task(i[2:0], 16'h0000, 16'h0000, 16'h0000);
        load_task(3'd1, 16'hFFFF, 16'h0000, 16'h0000);
        send_tick();
        send_tick();
        load_task(3'd1, 16'h0000, 16'h0000, 16'h0000);
        load_task(3'd5, 16'd3, 16'hFFFF, 16'hFFFF);
        load_task(3'd6, 16'd4, 16'd2, 16'd0);
        repeat (9) send_tick();
        gaps_on = 1'b1;

        random_run(400);

        finish_work();
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("** least_laxity_first_scheduler: PASSED **");
        end else begin
            $display("** least_laxity_first_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
